@@ design/dfp_pkg.sv @@
// ============================================================================
// Discovery frame parser package
// Shared constants, codes, types and helper functions for the frame parser.
// ============================================================================
package dfp_pkg;

    // Longest kept string is STR_MAX_BYTES - 1 value bytes.
    localparam int STR_MAX_BYTES = 64;

    // The value index saturates where no comparison can change any more.
    localparam int VIDX_SAT = (STR_MAX_BYTES - 1 > 4) ? STR_MAX_BYTES - 1 : 4;
    localparam int VIDX_W   = $clog2(VIDX_SAT + 1);
    localparam logic [VIDX_W-1:0] VIDX_MAX  = VIDX_W'(VIDX_SAT);
    localparam logic [VIDX_W-1:0] STR_KEEP  = VIDX_W'(STR_MAX_BYTES - 1);
    localparam logic [VIDX_W-1:0] CAPS_LEN  = VIDX_W'(4);
    localparam logic [VIDX_W-1:0] VLAN_LEN  = VIDX_W'(2);

    // Byte positions within the frame.
    localparam logic [4:0] POS_VERSION  = 5'd8;
    localparam logic [4:0] POS_HOLDTIME = 5'd9;
    localparam logic [4:0] POS_CSUM_HI  = 5'd10;
    localparam logic [4:0] POS_CSUM_LO  = 5'd11;
    localparam logic [4:0] POS_TLV      = 5'd12;
    localparam logic [4:0] MIN_FRAME    = 5'd20;

    // Output queue geometry.
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);
    localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

    // Record kinds.
    localparam logic [1:0] KIND_STR_BEGIN = 2'd0;
    localparam logic [1:0] KIND_STR_BYTE  = 2'd1;
    localparam logic [1:0] KIND_SUMMARY   = 2'd2;

    // String tags.
    localparam logic [2:0] TAG_DEVID    = 3'd0;
    localparam logic [2:0] TAG_PORT     = 3'd1;
    localparam logic [2:0] TAG_SW       = 3'd2;
    localparam logic [2:0] TAG_PLATFORM = 3'd3;
    localparam logic [2:0] TAG_VTP      = 3'd4;
    localparam logic [2:0] TAG_NONE     = 3'd7;

    // Frame status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OK_ALT    = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_BAD_HDR   = 3'd3;
    localparam logic [2:0] ST_BAD_CSUM  = 3'd4;

    // TLV type codes, for string and non-string TLVs.
    localparam logic [15:0] TLV_DEVID    = 16'd1;
    localparam logic [15:0] TLV_PORT     = 16'd3;
    localparam logic [15:0] TLV_CAPS     = 16'd4;
    localparam logic [15:0] TLV_SW       = 16'd5;
    localparam logic [15:0] TLV_PLATFORM = 16'd6;
    localparam logic [15:0] TLV_VTP      = 16'd9;
    localparam logic [15:0] TLV_VLAN     = 16'd10;

    // Found flag bits.
    localparam logic [6:0] FLAG_CAPS = 7'h04;
    localparam logic [6:0] FLAG_VLAN = 7'h40;

    // Alternate checksum correction.
    localparam logic [15:0] ALT_SUM_ADJ = 16'hfeff;

    // TLV parse phases.
    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPE_HI = 3'd1,
        PH_TYPE_LO = 3'd2,
        PH_LEN_HI  = 3'd3,
        PH_LEN_LO  = 3'd4,
        PH_VALUE   = 3'd5
    } t_phase;

    // One result record.
    typedef struct packed {
        logic [1:0]  record_kind;
        logic [2:0]  string_tag;
        logic [7:0]  string_byte;
        logic [2:0]  status;
        logic [7:0]  proto_version;
        logic [7:0]  hold_seconds;
        logic [6:0]  found_flags;
        logic [31:0] capabilities;
        logic [15:0] native_vlan;
        logic        last_of_run;
    } t_result;

    // Expected LLC/SNAP header byte at a position.
    function automatic logic [7:0] llc_byte(input logic [2:0] pos);
        logic [7:0] v;
        unique case (pos)
            3'd0:    v = 8'haa;
            3'd1:    v = 8'haa;
            3'd2:    v = 8'h03;
            3'd3:    v = 8'h00;
            3'd4:    v = 8'h00;
            3'd5:    v = 8'h0c;
            3'd6:    v = 8'h20;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // String tag of a TLV type, TAG_NONE when the type is not a string.
    function automatic logic [2:0] str_tag_of(input logic [15:0] t);
        logic [2:0] v;
        unique case (t)
            TLV_DEVID:    v = TAG_DEVID;
            TLV_PORT:     v = TAG_PORT;
            TLV_SW:       v = TAG_SW;
            TLV_PLATFORM: v = TAG_PLATFORM;
            TLV_VTP:      v = TAG_VTP;
            default:      v = TAG_NONE;
        endcase
        return v;
    endfunction

    // Found flag bit of a string tag.
    function automatic logic [6:0] str_flag(input logic [2:0] tag);
        logic [6:0] v;
        unique case (tag)
            TAG_DEVID:    v = 7'h01;
            TAG_PORT:     v = 7'h02;
            TAG_SW:       v = 7'h08;
            TAG_PLATFORM: v = 7'h10;
            TAG_VTP:      v = 7'h20;
            default:      v = 7'h00;
        endcase
        return v;
    endfunction

    // Ones-complement add with end-around carry; one fold is enough for
    // two 16-bit operands.
    function automatic logic [15:0] fold_add(input logic [15:0] s, input logic [15:0] w);
        logic [16:0] t;
        t = {1'b0, s} + {1'b0, w};
        return t[15:0] + {15'd0, t[16]};
    endfunction

endpackage

@@ design/dfp_in_if.sv @@
// ============================================================================
// Discovery frame parser input channel
// Valid/ready channel that carries one frame byte and its last-byte mark.
// ============================================================================
interface dfp_in_if;

    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);

endinterface

@@ design/dfp_out_if.sv @@
// ============================================================================
// Discovery frame parser output channel
// Valid/ready channel that carries one string or summary record.
// ============================================================================
interface dfp_out_if;

    logic        valid;
    logic        ready;
    logic [1:0]  record_kind;
    logic [2:0]  string_tag;
    logic [7:0]  string_byte;
    logic [2:0]  status;
    logic [7:0]  proto_version;
    logic [7:0]  hold_seconds;
    logic [6:0]  found_flags;
    logic [31:0] capabilities;
    logic [15:0] native_vlan;
    logic        last_of_run;

    modport source (
        output valid, input ready,
        output record_kind, output string_tag, output string_byte, output status,
        output proto_version, output hold_seconds, output found_flags,
        output capabilities, output native_vlan, output last_of_run
    );
    modport sink (
        input valid, output ready,
        input record_kind, input string_tag, input string_byte, input status,
        input proto_version, input hold_seconds, input found_flags,
        input capabilities, input native_vlan, input last_of_run
    );

endinterface

@@ design/discovery_frame_parser.sv @@
// ============================================================================
// Discovery frame parser
// Checks the LLC/SNAP header and checksum of a discovery frame streamed one
// byte per transaction, and reports string TLVs and a frame summary.
// ============================================================================
//
//  Channel   Direction  Transaction carries
//  -------   ---------  ------------------------------------------------------
//  i_in      in         data_byte, last_byte: one frame byte
//  o_out     out        one string begin, string byte or frame summary record
//
//  Each byte is processed in the cycle it is accepted; its records enter a
//  four-entry output queue and appear on o_out from the next cycle on.
//  One byte per cycle is accepted while at least two queue entries are free;
//  a byte causes at most two records, so the queue output port sets the rate.
//  A stalled o_out fills the queue and then holds i_in.ready low.
//  i_rst_n is synchronous and active low; it clears parse state and the queue.
//  All parse state returns to its reset value after each frame's summary.
//
module discovery_frame_parser import dfp_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dfp_in_if.sink         i_in,
    dfp_out_if.source      o_out
);

    // Parse state.
    logic [4:0]        r_byte_count, n_byte_count;
    t_phase            r_phase,      n_phase;
    logic              r_header_ok,  n_header_ok;
    logic [15:0]       r_sum,        n_sum;
    logic [7:0]        r_pend_hi,    n_pend_hi;
    logic              r_pend_valid, n_pend_valid;
    logic [15:0]       r_rx_csum,    n_rx_csum;
    logic [7:0]        r_version,    n_version;
    logic [7:0]        r_hold,       n_hold;
    logic [6:0]        r_flags,      n_flags;
    logic [31:0]       r_caps,       n_caps;
    logic [15:0]       r_vlan,       n_vlan;
    logic [15:0]       r_tlv_type,   n_tlv_type;
    logic [15:0]       r_tlv_rem,    n_tlv_rem;
    logic [VIDX_W-1:0] r_vidx,       n_vidx;
    logic              r_stopped,    n_stopped;

    // Output queue.
    t_result           r_q [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wr_ptr;
    logic [OQ_AW-1:0]  r_rd_ptr;
    logic [OQ_CW-1:0]  r_count;

    logic              in_acc;
    logic              out_pop;
    logic [1:0]        push_cnt;
    t_result           res0;
    t_result           res1;

    // Per-byte working values.
    logic [4:0]        pos;
    logic [7:0]        b;
    logic [2:0]        cur_tag;
    logic [15:0]       tlv_len;
    logic [15:0]       rem_dec;
    logic              have_str;
    t_result           str_rec;
    t_result           sum_rec;
    logic [15:0]       s_odd;
    logic [15:0]       s_alt;
    logic [2:0]        fr_status;

    assign in_acc     = i_in.valid && i_in.ready;
    assign out_pop    = o_out.valid && o_out.ready;
    assign i_in.ready = (r_count <= OQ_CW'(OQ_DEPTH - 2));

    assign pos     = r_byte_count;
    assign b       = i_in.data_byte;
    assign cur_tag = str_tag_of(r_tlv_type);
    assign tlv_len = r_tlv_rem | {8'h00, b};
    assign rem_dec = r_tlv_rem - 16'd1;

    // Next parse state and the records caused by the current byte.
    always_comb begin
        n_byte_count = r_byte_count;
        n_phase      = r_phase;
        n_header_ok  = r_header_ok;
        n_sum        = r_sum;
        n_pend_hi    = r_pend_hi;
        n_pend_valid = r_pend_valid;
        n_rx_csum    = r_rx_csum;
        n_version    = r_version;
        n_hold       = r_hold;
        n_flags      = r_flags;
        n_caps       = r_caps;
        n_vlan       = r_vlan;
        n_tlv_type   = r_tlv_type;
        n_tlv_rem    = r_tlv_rem;
        n_vidx       = r_vidx;
        n_stopped    = r_stopped;
        have_str     = 1'b0;
        str_rec      = '0;

        if (pos < MIN_FRAME) begin
            n_byte_count = pos + 5'd1;
        end

        // Header bytes, fixed fields and received checksum.
        if (pos < POS_VERSION) begin
            if (b != llc_byte(pos[2:0])) begin
                n_header_ok = 1'b0;
            end
        end else if (pos == POS_VERSION) begin
            n_version = b;
        end else if (pos == POS_HOLDTIME) begin
            n_hold = b;
        end else if (pos == POS_CSUM_HI) begin
            n_rx_csum = {b, 8'h00};
        end else if (pos == POS_CSUM_LO) begin
            n_rx_csum = {r_rx_csum[15:8], b};
        end

        // Big-endian word sum with the checksum word skipped.
        if (pos >= POS_VERSION && pos != POS_CSUM_HI && pos != POS_CSUM_LO) begin
            if (r_pend_valid) begin
                n_sum        = fold_add(r_sum, {r_pend_hi, b});
                n_pend_valid = 1'b0;
            end else begin
                n_pend_hi    = b;
                n_pend_valid = 1'b1;
            end
        end

        // TLV parsing.
        if (pos == POS_CSUM_LO) begin
            n_phase = PH_TYPE_HI;
        end else if (pos >= POS_TLV && r_header_ok && !r_stopped) begin
            unique case (r_phase)
                PH_TYPE_HI: begin
                    n_tlv_type = {b, 8'h00};
                    n_phase    = PH_TYPE_LO;
                end
                PH_TYPE_LO: begin
                    n_tlv_type = {r_tlv_type[15:8], b};
                    n_phase    = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_tlv_rem = {b, 8'h00};
                    n_phase   = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    if (tlv_len < 16'd4) begin
                        n_stopped = 1'b1;
                    end else begin
                        n_tlv_rem = tlv_len - 16'd4;
                        n_vidx    = '0;
                        if (cur_tag != TAG_NONE) begin
                            n_flags             = r_flags | str_flag(cur_tag);
                            have_str            = 1'b1;
                            str_rec.record_kind = KIND_STR_BEGIN;
                            str_rec.string_tag  = cur_tag;
                        end else if (r_tlv_type == TLV_CAPS) begin
                            n_flags = r_flags | FLAG_CAPS;
                            n_caps  = '0;
                        end else if (r_tlv_type == TLV_VLAN) begin
                            n_flags = r_flags | FLAG_VLAN;
                            n_vlan  = '0;
                        end
                        n_phase = (n_tlv_rem != 16'd0) ? PH_VALUE : PH_TYPE_HI;
                    end
                end
                PH_VALUE: begin
                    if (cur_tag != TAG_NONE) begin
                        if (r_vidx < STR_KEEP) begin
                            have_str            = 1'b1;
                            str_rec.record_kind = KIND_STR_BYTE;
                            str_rec.string_tag  = cur_tag;
                            str_rec.string_byte = b;
                        end
                    end else if (r_tlv_type == TLV_CAPS) begin
                        if (r_vidx < CAPS_LEN) begin
                            n_caps = r_caps
                                   | ({24'h0, b} << {2'd3 - r_vidx[1:0], 3'b000});
                        end
                    end else if (r_tlv_type == TLV_VLAN) begin
                        if (r_vidx < VLAN_LEN) begin
                            n_vlan = r_vlan | ({8'h00, b} << {~r_vidx[0], 3'b000});
                        end
                    end
                    if (r_vidx < VIDX_MAX) begin
                        n_vidx = r_vidx + VIDX_W'(1);
                    end
                    n_tlv_rem = rem_dec;
                    if (rem_dec == 16'd0) begin
                        n_phase = PH_TYPE_HI;
                    end
                end
                default: begin
                    n_phase = PH_TYPE_HI;
                end
            endcase
        end

        str_rec.last_of_run = !i_in.last_byte;

        // Frame end: fold in an odd trailing byte and grade the checksum.
        s_odd = n_pend_valid ? fold_add(n_sum, {8'h00, n_pend_hi}) : n_sum;
        s_alt = fold_add(s_odd, ALT_SUM_ADJ);
        priority if (n_byte_count < MIN_FRAME) begin
            fr_status = ST_SHORT;
        end else if (!n_header_ok) begin
            fr_status = ST_BAD_HDR;
        end else if (~s_odd == n_rx_csum) begin
            fr_status = ST_OK;
        end else if (n_pend_valid && (~s_alt == n_rx_csum)) begin
            fr_status = ST_OK_ALT;
        end else begin
            fr_status = ST_BAD_CSUM;
        end

        sum_rec               = '0;
        sum_rec.record_kind   = KIND_SUMMARY;
        sum_rec.status        = fr_status;
        sum_rec.proto_version = n_version;
        sum_rec.hold_seconds  = n_hold;
        sum_rec.found_flags   = n_flags;
        sum_rec.capabilities  = n_caps;
        sum_rec.native_vlan   = n_vlan;
        sum_rec.last_of_run   = 1'b1;

        // All parse state starts over after the summary.
        if (i_in.last_byte) begin
            n_byte_count = '0;
            n_phase      = PH_HEADER;
            n_header_ok  = 1'b1;
            n_sum        = '0;
            n_pend_hi    = '0;
            n_pend_valid = 1'b0;
            n_rx_csum    = '0;
            n_version    = '0;
            n_hold       = '0;
            n_flags      = '0;
            n_caps       = '0;
            n_vlan       = '0;
            n_tlv_type   = '0;
            n_tlv_rem    = '0;
            n_vidx       = '0;
            n_stopped    = 1'b0;
        end
    end

    // Order the records of this byte for the queue.
    always_comb begin
        if (have_str) begin
            res0     = str_rec;
            res1     = sum_rec;
            push_cnt = i_in.last_byte ? 2'd2 : 2'd1;
        end else begin
            res0     = sum_rec;
            res1     = sum_rec;
            push_cnt = i_in.last_byte ? 2'd1 : 2'd0;
        end
        if (!in_acc) begin
            push_cnt = 2'd0;
        end
    end

    // Parse state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_phase      <= PH_HEADER;
            r_header_ok  <= 1'b1;
            r_sum        <= '0;
            r_pend_hi    <= '0;
            r_pend_valid <= 1'b0;
            r_rx_csum    <= '0;
            r_version    <= '0;
            r_hold       <= '0;
            r_flags      <= '0;
            r_caps       <= '0;
            r_vlan       <= '0;
            r_tlv_type   <= '0;
            r_tlv_rem    <= '0;
            r_vidx       <= '0;
            r_stopped    <= 1'b0;
        end else if (in_acc) begin
            r_byte_count <= n_byte_count;
            r_phase      <= n_phase;
            r_header_ok  <= n_header_ok;
            r_sum        <= n_sum;
            r_pend_hi    <= n_pend_hi;
            r_pend_valid <= n_pend_valid;
            r_rx_csum    <= n_rx_csum;
            r_version    <= n_version;
            r_hold       <= n_hold;
            r_flags      <= n_flags;
            r_caps       <= n_caps;
            r_vlan       <= n_vlan;
            r_tlv_type   <= n_tlv_type;
            r_tlv_rem    <= n_tlv_rem;
            r_vidx       <= n_vidx;
            r_stopped    <= n_stopped;
        end
    end

    // Output queue storage.
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_q[r_wr_ptr] <= res0;
        end
        if (push_cnt == 2'd2) begin
            r_q[r_wr_ptr + OQ_AW'(1)] <= res1;
        end
    end

    // Output queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + OQ_AW'(push_cnt);
            if (out_pop) begin
                r_rd_ptr <= r_rd_ptr + OQ_AW'(1);
            end
            r_count <= r_count + OQ_CW'(push_cnt) - OQ_CW'(out_pop);
        end
    end

    // Queue head drives the output channel.
    assign o_out.valid         = (r_count != '0);
    assign o_out.record_kind   = r_q[r_rd_ptr].record_kind;
    assign o_out.string_tag    = r_q[r_rd_ptr].string_tag;
    assign o_out.string_byte   = r_q[r_rd_ptr].string_byte;
    assign o_out.status        = r_q[r_rd_ptr].status;
    assign o_out.proto_version = r_q[r_rd_ptr].proto_version;
    assign o_out.hold_seconds  = r_q[r_rd_ptr].hold_seconds;
    assign o_out.found_flags   = r_q[r_rd_ptr].found_flags;
    assign o_out.capabilities  = r_q[r_rd_ptr].capabilities;
    assign o_out.native_vlan   = r_q[r_rd_ptr].native_vlan;
    assign o_out.last_of_run   = r_q[r_rd_ptr].last_of_run;

    // The queue never holds more records than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_CW'(OQ_DEPTH))
        else $error("output queue overflow");

    // The frame end returns the byte counter to the start of a frame.
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in.last_byte |=> r_byte_count == '0 && r_phase == PH_HEADER)
        else $error("parse state not cleared after frame end");

    // Past the checksum word the parser has left the header phase.
    a_phase_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_byte_count >= POS_TLV |-> r_phase != PH_HEADER)
        else $error("header phase beyond the checksum word");

    // A summary record always closes the run of its byte.
    a_summary_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.record_kind == KIND_SUMMARY |-> o_out.last_of_run)
        else $error("summary record not last of its run");

endmodule
